@@ rtl/tdts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdts_pkg: shared types and constants of the transfer descriptor splitter
// Widths, result kinds, sequencer control word and the microprogram ROM.
// ----------------------------------------------------------------------------
package tdts_pkg;

	localparam int RING_SLOTS_DEF   = 32;
	localparam int MAX_SEGMENTS_DEF = 8;

	localparam int ADDR_W     = 32;
	localparam int LEN_W      = 20;
	localparam int MPS_W      = 11;
	localparam int SEG_W      = 17;
	localparam int PKT_W      = 5;
	localparam int SLOT_OUT_W = 5;
	localparam int DIV_W      = 21;
	localparam int DIV_CNT_W  = 5;
	localparam int RESULT_CAP = 17;
	localparam int RES_CNT_W  = 5;
	localparam int PC_W       = 4;

	localparam logic [SEG_W-1:0] PIECE_SPAN = 17'h10000;

	typedef enum logic [1:0] {
		KIND_NORMAL = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_LINK   = 2'd2
	} trb_kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_CEIL,
		OP_SAVE_CEIL,
		OP_DIV_CONS,
		OP_EMIT_DESC,
		OP_EMIT_LINK,
		OP_EMIT_REJ,
		OP_ADVANCE
	} seq_op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_OVERSIZE,
		COND_DIV_BUSY,
		COND_OUT_BUSY,
		COND_NO_LINK,
		COND_MORE
	} seq_cond_t;

	typedef struct packed {
		seq_op_t         op;
		seq_cond_t       cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	// Microprogram step addresses
	localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] STEP_CHECK = 4'd1;
	localparam logic [PC_W-1:0] STEP_DIVC  = 4'd2;
	localparam logic [PC_W-1:0] STEP_WAITC = 4'd3;
	localparam logic [PC_W-1:0] STEP_SAVEC = 4'd4;
	localparam logic [PC_W-1:0] STEP_PIECE = 4'd5;
	localparam logic [PC_W-1:0] STEP_WAITP = 4'd6;
	localparam logic [PC_W-1:0] STEP_EMITD = 4'd7;
	localparam logic [PC_W-1:0] STEP_LCHK  = 4'd8;
	localparam logic [PC_W-1:0] STEP_LINK  = 4'd9;
	localparam logic [PC_W-1:0] STEP_ADV   = 4'd10;
	localparam logic [PC_W-1:0] STEP_END   = 4'd11;
	localparam logic [PC_W-1:0] STEP_REJ   = 4'd12;
	localparam logic [PC_W-1:0] STEP_REND  = 4'd13;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [MPS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	// Jump to target when the condition holds, else fall through to the next step
	function automatic ctrl_word_t seq_rom(input logic [PC_W-1:0] step);
		ctrl_word_t w;
		w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
		case (step)
			STEP_IDLE:  w = '{op: OP_LOAD,      cond: COND_NO_INPUT, target: STEP_IDLE};
			STEP_CHECK: w = '{op: OP_NONE,      cond: COND_OVERSIZE, target: STEP_REJ};
			STEP_DIVC:  w = '{op: OP_DIV_CEIL,  cond: COND_NEVER,    target: STEP_IDLE};
			STEP_WAITC: w = '{op: OP_NONE,      cond: COND_DIV_BUSY, target: STEP_WAITC};
			STEP_SAVEC: w = '{op: OP_SAVE_CEIL, cond: COND_NEVER,    target: STEP_IDLE};
			STEP_PIECE: w = '{op: OP_DIV_CONS,  cond: COND_NEVER,    target: STEP_IDLE};
			STEP_WAITP: w = '{op: OP_NONE,      cond: COND_DIV_BUSY, target: STEP_WAITP};
			STEP_EMITD: w = '{op: OP_EMIT_DESC, cond: COND_OUT_BUSY, target: STEP_EMITD};
			STEP_LCHK:  w = '{op: OP_NONE,      cond: COND_NO_LINK,  target: STEP_ADV};
			STEP_LINK:  w = '{op: OP_EMIT_LINK, cond: COND_OUT_BUSY, target: STEP_LINK};
			STEP_ADV:   w = '{op: OP_ADVANCE,   cond: COND_MORE,     target: STEP_PIECE};
			STEP_END:   w = '{op: OP_NONE,      cond: COND_ALWAYS,   target: STEP_IDLE};
			STEP_REJ:   w = '{op: OP_EMIT_REJ,  cond: COND_OUT_BUSY, target: STEP_REJ};
			STEP_REND:  w = '{op: OP_NONE,      cond: COND_ALWAYS,   target: STEP_IDLE};
			default:    w = '{op: OP_NONE,      cond: COND_ALWAYS,   target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/tdts_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdts_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdts_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tdts_pkg::div_req_t req,
	output tdts_pkg::div_rsp_t rsp
);
	import tdts_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [MPS_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [MPS_W-1:0]     dvs_q;

	logic [MPS_W:0]   trial;
	logic [MPS_W:0]   diff;
	logic             ge;
	logic [MPS_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[DIV_W-1]};
		diff     = trial - {1'b0, dvs_q};
		ge       = trial >= {1'b0, dvs_q};
		rem_next = ge ? diff[MPS_W-1:0] : trial[MPS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift the dividend out as the quotient shifts in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = quo_q;

endmodule

@@ rtl/transfer_descriptor_trb_splitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transfer_descriptor_trb_splitter: transfer request to ring descriptors
// Cuts a buffer at 64 KiB boundaries into descriptors, tracks the enqueue
// slot and producer cycle of a single-segment ring and emits link updates.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/s_axis_tready   one transfer request
// m_axis    out  m_axis_tvalid/m_axis_tready   descriptor, link update or reject
//
// A microcoded sequencer runs a ROM program; a shared bit-serial divider
// gives the packet counts. Output stalls hold the sequencer at its emit
// step. Reset puts the enqueue slot at 0 and the producer cycle at 1; one
// request is worked on at a time.
// ----------------------------------------------------------------------------
module transfer_descriptor_trb_splitter #(
	parameter int RING_SLOTS   = tdts_pkg::RING_SLOTS_DEF,
	parameter int MAX_SEGMENTS = tdts_pkg::MAX_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] buffer_address, [51:32] byte_length, [62:52] max_packet_size,
	// [63] direction_in
	input  logic [63:0] s_axis_tdata,
	// [0] is_control_data
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] slot_index, [36:5] segment_address, [53:37] segment_length,
	// [58:54] packets_left, [59] chain_flag, [60] irq_on_complete,
	// [61] stage_direction, [62] cycle_bit, [63] zero
	output logic [63:0] m_axis_tdata,
	// [1:0] trb_kind, [2] rejected
	output logic [2:0]  m_axis_tuser,
	// last_of_run
	output logic        m_axis_tlast
);
	import tdts_pkg::*;

	localparam int SLOT_W = $clog2(RING_SLOTS);
	localparam logic [SLOT_W-1:0]     SLOT_PRE_LINK = SLOT_W'(RING_SLOTS - 2);
	localparam logic [SLOT_OUT_W-1:0] LINK_SLOT     = SLOT_OUT_W'((RING_SLOTS - 1) % 32);
	localparam logic [DIV_W-1:0]      SEG_LIMIT     = DIV_W'(MAX_SEGMENTS * 65536);

	// Sequencer
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	ctrl_word_t      ctrl;
	logic            cond_true;

	// Request registers
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  rem_len_q;
	logic [LEN_W-1:0]  cons_q;
	logic [MPS_W-1:0]  mps_q;
	logic              ctrl_q;
	logic              dir_q;
	logic              first_q;
	logic [DIV_W-1:0]  ceil_q;

	// Ring state
	logic [SLOT_W-1:0]    slot_q;
	logic                 cycle_q;
	logic                 link_pend_q;
	logic [RES_CNT_W-1:0] res_cnt_q;

	// Output register
	logic                  out_valid_q;
	logic [SLOT_OUT_W-1:0] o_slot_q;
	trb_kind_t             o_kind_q;
	logic [ADDR_W-1:0]     o_addr_q;
	logic [SEG_W-1:0]      o_len_q;
	logic [PKT_W-1:0]      o_pkts_q;
	logic                  o_chain_q;
	logic                  o_irq_q;
	logic                  o_dir_q;
	logic                  o_cycle_q;
	logic                  o_rej_q;
	logic                  o_last_q;

	// Datapath
	div_req_t              div_req;
	div_rsp_t              div_rsp;
	logic [SEG_W-1:0]      span;
	logic                  piece_last;
	logic [SEG_W-1:0]      piece_len;
	logic                  oversize;
	logic                  out_free;
	logic                  accept;
	logic                  emit_fire;
	logic                  out_load;
	logic                  link_follows;
	logic                  cap_last;
	logic                  data_stage;
	logic [DIV_W-1:0]      pkt_diff;
	logic [PKT_W-1:0]      pkt_left;
	logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

	logic [SLOT_OUT_W-1:0] n_slot;
	trb_kind_t             n_kind;
	logic [ADDR_W-1:0]     n_addr;
	logic [SEG_W-1:0]      n_len;
	logic [PKT_W-1:0]      n_pkts;
	logic                  n_chain;
	logic                  n_irq;
	logic                  n_dir;
	logic                  n_rej;
	logic                  n_last;

	tdts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Current piece: up to the next 64 KiB boundary, or the rest of the buffer
	always_comb begin
		span       = PIECE_SPAN - {1'b0, addr_q[15:0]};
		piece_last = rem_len_q <= LEN_W'(span);
		piece_len  = piece_last ? SEG_W'(rem_len_q) : span;
		oversize   = ({5'b0, addr_q[15:0]} + {1'b0, rem_len_q}) > SEG_LIMIT;
	end

	assign ctrl          = seq_rom(pc_q);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (ctrl.op == OP_LOAD);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign emit_fire     = out_free && ((ctrl.op == OP_EMIT_DESC) ||
		(ctrl.op == OP_EMIT_LINK) || (ctrl.op == OP_EMIT_REJ));
	// Results beyond the cap are dropped; state still advances
	assign out_load      = emit_fire && (res_cnt_q < RES_CNT_W'(RESULT_CAP));

	always_comb begin
		case (ctrl.cond)
			COND_NEVER:    cond_true = 1'b0;
			COND_ALWAYS:   cond_true = 1'b1;
			COND_NO_INPUT: cond_true = !s_axis_tvalid;
			COND_OVERSIZE: cond_true = oversize;
			COND_DIV_BUSY: cond_true = div_rsp.busy;
			COND_OUT_BUSY: cond_true = !out_free;
			COND_NO_LINK:  cond_true = !link_pend_q;
			COND_MORE:     cond_true = !piece_last;
			default:       cond_true = 1'b1;
		endcase
		pc_next = cond_true ? ctrl.target : pc_q + 1'b1;
	end

	// Ceiling packet count first, then the floor of bytes consumed per piece
	always_comb begin
		div_req.start    = (ctrl.op == OP_DIV_CEIL) || ((ctrl.op == OP_DIV_CONS) && !piece_last);
		div_req.divisor  = mps_q;
		div_req.dividend = (ctrl.op == OP_DIV_CEIL)
			? DIV_W'(rem_len_q) + DIV_W'(mps_q) - 1'b1
			: DIV_W'(cons_q) + DIV_W'(span);
	end

	always_comb begin
		pkt_diff     = ceil_q - div_rsp.quotient;
		pkt_left     = piece_last ? '0 :
			((|pkt_diff[DIV_W-1:PKT_W]) ? '1 : pkt_diff[PKT_W-1:0]);
		link_follows = (slot_q == SLOT_PRE_LINK);
		cap_last     = (res_cnt_q == RES_CNT_W'(RESULT_CAP - 1));
		data_stage   = first_q && ctrl_q;
		slot_wide    = (SLOT_W + SLOT_OUT_W)'(slot_q);
	end

	// Select the fields of the result being emitted
	always_comb begin
		n_slot  = '0;
		n_kind  = KIND_NORMAL;
		n_addr  = '0;
		n_len   = '0;
		n_pkts  = '0;
		n_chain = 1'b0;
		n_irq   = 1'b0;
		n_dir   = 1'b0;
		n_rej   = 1'b0;
		n_last  = 1'b1;
		case (ctrl.op)
			OP_EMIT_DESC: begin
				n_slot  = slot_wide[SLOT_OUT_W-1:0];
				n_kind  = data_stage ? KIND_DATA : KIND_NORMAL;
				n_addr  = addr_q;
				n_len   = piece_len;
				n_pkts  = pkt_left;
				n_chain = !piece_last;
				n_irq   = piece_last;
				n_dir   = data_stage && dir_q;
				n_last  = (piece_last && !link_follows) || cap_last;
			end
			OP_EMIT_LINK: begin
				n_slot  = LINK_SLOT;
				n_kind  = KIND_LINK;
				n_chain = !piece_last;
				n_last  = piece_last || cap_last;
			end
			OP_EMIT_REJ: begin
				n_rej  = 1'b1;
			end
			default: begin
				n_last = 1'b1;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			slot_q      <= '0;
			cycle_q     <= 1'b1;
			link_pend_q <= 1'b0;
			res_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (accept) begin
				res_cnt_q <= '0;
			end else if (out_load) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end
			// Advance the enqueue slot; arm a link update ahead of the link slot
			if (emit_fire && (ctrl.op == OP_EMIT_DESC)) begin
				if (link_follows) begin
					slot_q      <= '0;
					link_pend_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			// Toggle the producer cycle once the link update is out
			if (emit_fire && (ctrl.op == OP_EMIT_LINK)) begin
				cycle_q     <= !cycle_q;
				link_pend_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q    <= s_axis_tdata[31:0];
			rem_len_q <= s_axis_tdata[51:32];
			cons_q    <= '0;
			mps_q     <= (s_axis_tdata[62:52] == '0) ? MPS_W'(1) : s_axis_tdata[62:52];
			dir_q     <= s_axis_tdata[63];
			ctrl_q    <= s_axis_tuser;
			first_q   <= 1'b1;
		end else if (ctrl.op == OP_ADVANCE) begin
			addr_q    <= addr_q + ADDR_W'(piece_len);
			rem_len_q <= rem_len_q - LEN_W'(piece_len);
			cons_q    <= cons_q + LEN_W'(piece_len);
			first_q   <= 1'b0;
		end
		if (ctrl.op == OP_SAVE_CEIL) begin
			ceil_q <= div_rsp.quotient;
		end
	end

	// Output payload: hold while the transaction waits
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_slot_q  <= n_slot;
			o_kind_q  <= n_kind;
			o_addr_q  <= n_addr;
			o_len_q   <= n_len;
			o_pkts_q  <= n_pkts;
			o_chain_q <= n_chain;
			o_irq_q   <= n_irq;
			o_dir_q   <= n_dir;
			o_cycle_q <= n_rej ? 1'b0 : cycle_q;
			o_rej_q   <= n_rej;
			o_last_q  <= n_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, o_cycle_q, o_dir_q, o_irq_q, o_chain_q, o_pkts_q,
		o_len_q, o_addr_q, o_slot_q};
	assign m_axis_tuser  = {o_rej_q, o_kind_q};
	assign m_axis_tlast  = o_last_q;

`ifndef NO_ASSERTIONS
	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_link_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		link_pend_q |-> (slot_q == '0))
		else $error("pending link update with nonzero enqueue slot");

	a_cycle_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && (ctrl.op == OP_EMIT_LINK)) |=> (cycle_q != $past(cycle_q)))
		else $error("producer cycle did not toggle after link update");

	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= RES_CNT_W'(RESULT_CAP))
		else $error("result count beyond cap");
`endif

endmodule

@@ tb/sv/transfer_descriptor_trb_splitter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transfer_descriptor_trb_splitter_tb: self-checking stream testbench
// Drives transfer requests into the splitter and checks every descriptor,
// link update and reject against an in-bench model of the ring producer.
// Covers boundary requests, random traffic, random idle cycles on both sides,
// a long output stall, and pauses that let the block run dry.
// ----------------------------------------------------------------------------
module transfer_descriptor_trb_splitter_tb;
	import tdts_pkg::*;

	localparam int RING        = RING_SLOTS_DEF;
	localparam int SEGS        = MAX_SEGMENTS_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PRINT_CAP   = 40;

	// One expected ring write, descriptor or link update, or a reject
	typedef struct {
		logic [4:0]  slot;
		trb_kind_t   kind;
		logic [31:0] seg_addr;
		logic [16:0] seg_len;
		logic [4:0]  pkts_left;
		logic        chain;
		logic        ioc;
		logic        dir;
		logic        cycle;
		logic        rejected;
		logic        last;
	} trb_result_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [31:0] buffer_address, [51:32] byte_length, [62:52] max_packet_size,
	// [63] direction_in
	logic [63:0] s_axis_tdata  = '0;
	// [0] is_control_data
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [4:0] slot_index, [36:5] segment_address, [53:37] segment_length,
	// [58:54] packets_left, [59] chain_flag, [60] irq_on_complete,
	// [61] stage_direction, [62] cycle_bit, [63] zero
	logic [63:0] m_axis_tdata;
	// [1:0] trb_kind, [2] rejected
	logic [2:0]  m_axis_tuser;
	// last_of_run
	logic        m_axis_tlast;

	// Ring producer state as the bench sees it
	int          ring_slot  = 0;
	logic        prod_cycle = 1'b1;
	trb_result_t pending_trbs[$];

	// Idle control shared by the stimulus tasks and the receiver process
	int tx_gap_max     = 0;
	int rx_stall_max   = 0;
	int rx_hold_cycles = 0;

	int cycle_count       = 0;
	int mismatch_count    = 0;
	int results_seen      = 0;
	int requests_accepted = 0;
	int desc_seen         = 0;
	int data_stage_seen   = 0;
	int link_seen         = 0;
	int reject_seen       = 0;

	transfer_descriptor_trb_splitter #(
		.RING_SLOTS  (RING),
		.MAX_SEGMENTS(SEGS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, pending_trbs.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic trb_result_t blank_trb();
		trb_result_t r;
		r.slot      = '0;
		r.kind      = KIND_NORMAL;
		r.seg_addr  = '0;
		r.seg_len   = '0;
		r.pkts_left = '0;
		r.chain     = 1'b0;
		r.ioc       = 1'b0;
		r.dir       = 1'b0;
		r.cycle     = 1'b0;
		r.rejected  = 1'b0;
		r.last      = 1'b0;
		return r;
	endfunction

	// Cut one request into ring writes and queue them in emit order.
	// Advances the enqueue slot and producer cycle exactly as the block should.
	task automatic predict_split(input logic [31:0] addr_in, input logic [19:0] len_in,
			input logic [10:0] mps_in, input logic ctrl, input logic dir_in);
		logic [31:0] addr;
		logic [31:0] remaining;
		logic [31:0] mps;
		logic [31:0] packets;
		logic [31:0] residue;
		logic [31:0] piece_len;
		logic        last;
		int          made;
		trb_result_t run[$];
		trb_result_t r;

		addr      = addr_in;
		remaining = 32'(len_in);
		mps       = (mps_in == '0) ? 32'd1 : 32'(mps_in);
		residue   = '0;
		made      = 0;

		// Oversize: single reject, ring state untouched
		if (32'(addr[15:0]) + remaining > 32'(SEGS) * 32'h10000) begin
			r = blank_trb();
			r.rejected = 1'b1;
			r.last     = 1'b1;
			pending_trbs.push_back(r);
			return;
		end

		packets = (remaining + mps - 1) / mps;
		while (remaining != 0 || made == 0) begin
			piece_len = ((addr + 32'h10000) & ~32'hffff) - addr;
			if (remaining <= piece_len) begin
				piece_len = remaining;
				remaining = '0;
				packets   = '0;
			end else begin
				packets   = packets - (residue + piece_len) / mps;
				residue   = (residue + piece_len) % mps;
				remaining = remaining - piece_len;
			end
			last = (remaining == 0);

			r = blank_trb();
			r.slot      = 5'(ring_slot);
			r.seg_addr  = addr;
			r.seg_len   = 17'(piece_len);
			r.pkts_left = (packets > 31) ? 5'd31 : 5'(packets);
			r.chain     = ~last;
			r.ioc       = last;
			r.cycle     = prod_cycle;
			if (made == 0 && ctrl) begin
				r.kind = KIND_DATA;
				r.dir  = dir_in;
			end
			if (run.size() < RESULT_CAP)
				run.push_back(r);

			// Reaching the link slot: emit the update, toggle cycle, wrap
			ring_slot++;
			if (ring_slot >= RING - 1) begin
				r = blank_trb();
				r.slot  = 5'(RING - 1);
				r.kind  = KIND_LINK;
				r.chain = ~last;
				r.cycle = prod_cycle;
				if (run.size() < RESULT_CAP)
					run.push_back(r);
				prod_cycle = ~prod_cycle;
				ring_slot  = 0;
			end

			addr = addr + piece_len;
			made++;
		end

		run[run.size() - 1].last = 1'b1;
		foreach (run[i])
			pending_trbs.push_back(run[i]);
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at result %0d (cycle %0d): %s", results_seen, cycle_count, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// Compare every accepted output transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		trb_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_trbs.size() == 0) begin
				report_mismatch("output transaction with no result pending");
			end else begin
				want = pending_trbs.pop_front();
				check_field("slot_index",      32'(m_axis_tdata[4:0]),   32'(want.slot));
				check_field("segment_address", m_axis_tdata[36:5],       want.seg_addr);
				check_field("segment_length",  32'(m_axis_tdata[53:37]), 32'(want.seg_len));
				check_field("packets_left",    32'(m_axis_tdata[58:54]), 32'(want.pkts_left));
				check_field("chain_flag",      32'(m_axis_tdata[59]),    32'(want.chain));
				check_field("irq_on_complete", 32'(m_axis_tdata[60]),    32'(want.ioc));
				check_field("stage_direction", 32'(m_axis_tdata[61]),    32'(want.dir));
				check_field("cycle_bit",       32'(m_axis_tdata[62]),    32'(want.cycle));
				check_field("tdata pad bit",   32'(m_axis_tdata[63]),    '0);
				check_field("trb_kind",        32'(m_axis_tuser[1:0]),   32'(want.kind));
				check_field("rejected",        32'(m_axis_tuser[2]),     32'(want.rejected));
				check_field("last_of_run",     32'(m_axis_tlast),        32'(want.last));
				if (want.rejected)
					reject_seen++;
				else if (want.kind == KIND_LINK)
					link_seen++;
				else
					desc_seen++;
				if (want.kind == KIND_DATA)
					data_stage_seen++;
			end
		end
	end

	// Output side: random stall before each transaction, plus a long hold-off
	// whenever a test requests one. Hold tready high until the handshake lands.
	initial begin : result_receiver
		int stall;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, rx_stall_max) + rx_hold_cycles;
			rx_hold_cycles = 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// Offer one request after a random gap; predict its results on acceptance.
	// Enter and leave at a falling edge.
	task automatic send_request(input logic [31:0] addr, input logic [19:0] len,
			input logic [10:0] mps, input logic ctrl, input logic dir_in);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= {dir_in, mps, len, addr};
		s_axis_tuser  <= ctrl;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		predict_split(addr, len, mps, ctrl, dir_in);
		requests_accepted++;
		@(negedge clk);
	endtask

	// Drop tvalid and wait until every predicted result has come out
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_trbs.size() != 0)
			@(negedge clk);
	endtask

	// Mostly legal requests with a spread of offsets, lengths and packet sizes;
	// a few oversize ones and raw 11-bit packet sizes as noise.
	task automatic draw_request(output logic [31:0] addr, output logic [19:0] len,
			output logic [10:0] mps, output logic ctrl, output logic dir_in);
		int          pick;
		logic [31:0] room;
		pick = $urandom_range(0, 99);
		addr = $urandom();
		if (pick < 15)
			addr[15:0] = '0;
		else if (pick < 30)
			addr[15:0] = 16'(32'h10000 - $urandom_range(1, 256));
		room = 32'(SEGS) * 32'h10000 - 32'(addr[15:0]);

		pick = $urandom_range(0, 99);
		if (pick < 10)
			len = '0;
		else if (pick < 45)
			len = 20'($urandom_range(1, 2048));
		else if (pick < 70)
			len = 20'($urandom_range(1, 32'h20000));
		else if (pick < 88)
			len = 20'($urandom_range(0, room));
		else if (pick < 94)
			len = 20'(room);
		else
			len = 20'($urandom_range(room + 1, 32'hfffff));

		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			case ($urandom_range(0, 5))
				0: mps = 11'd8;
				1: mps = 11'd16;
				2: mps = 11'd32;
				3: mps = 11'd64;
				4: mps = 11'd512;
				default: mps = 11'd1024;
			endcase
		end else if (pick < 90) begin
			mps = 11'($urandom_range(1, 1024));
		end else begin
			mps = 11'($urandom_range(0, 2047));
		end

		ctrl   = ($urandom_range(0, 9) < 3);
		dir_in = 1'($urandom_range(0, 1));
	endtask

	task automatic send_random_request();
		logic [31:0] addr;
		logic [19:0] len;
		logic [10:0] mps;
		logic        ctrl;
		logic        dir_in;
		draw_request(addr, len, mps, ctrl, dir_in);
		send_request(addr, len, mps, ctrl, dir_in);
	endtask

	// Field extremes, zero length, zero and maximum packet size, address wrap,
	// exact fit and one-over, residue carry and ring wrap in mid-transfer
	task automatic test_boundary_requests();
		tx_gap_max   = 14;
		rx_stall_max = 14;
		send_request(32'h0000_0000, 20'h00000, 11'd64,   1'b0, 1'b0);
		send_request(32'h1234_0000, 20'h00000, 11'd8,    1'b1, 1'b1);
		send_request(32'h0000_0100, 20'd1000,  11'd0,    1'b0, 1'b0);
		send_request(32'h8000_0000, 20'd3000,  11'd2047, 1'b1, 1'b0);
		send_request(32'h0000_0000, 20'h80000, 11'd512,  1'b1, 1'b1);
		send_request(32'h0000_0001, 20'h80000, 11'd512,  1'b0, 1'b0);
		send_request(32'hffff_ffff, 20'hfffff, 11'd1024, 1'b1, 1'b1);
		send_request(32'hffff_ffff, 20'h00001, 11'd1,    1'b0, 1'b0);
		send_request(32'hffff_0010, 20'h20000, 11'd64,   1'b1, 1'b0);
		send_request(32'h0001_ffff, 20'h70001, 11'd1,    1'b0, 1'b0);
		send_request(32'h0002_0000, 20'h10000, 11'd1024, 1'b0, 1'b0);
		send_request(32'h0002_8000, 20'h10000, 11'd1000, 1'b0, 1'b1);
		send_request(32'h0003_fff0, 20'h30000, 11'd3,    1'b1, 1'b1);
		send_request(32'h5555_aaaa, 20'h55555, 11'h555,  1'b0, 1'b1);
		send_request(32'haaaa_5555, 20'h2aaaa, 11'h2aa,  1'b1, 1'b0);
		for (int i = 0; i < 5; i++)
			send_request(32'(i) << 20, 20'h30000 + 20'(i), 11'd512, 1'(i), 1'(i >> 1));
		drain_results();
	endtask

	// Random requests; redraw idle limits every 25 items so that busy
	// stretches alternate with gappy ones on each side
	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 25 == 0) begin
				tx_gap_max   = $urandom_range(0, 1) ? 14 : 0;
				rx_stall_max = $urandom_range(0, 1) ? 14 : 0;
			end
			send_random_request();
		end
		drain_results();
	endtask

	// Stall the output for a long stretch while requests keep coming,
	// so the block backs up and holds off its input
	task automatic test_receiver_hold_off();
		tx_gap_max     = 0;
		rx_stall_max   = 14;
		rx_hold_cycles = 400;
		for (int i = 0; i < 20; i++)
			send_random_request();
		drain_results();
	endtask

	// Short bursts with the sender waiting for every result in between
	task automatic test_pause_until_drained();
		tx_gap_max   = 14;
		rx_stall_max = 14;
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 3; j++)
				send_random_request();
			drain_results();
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_boundary_requests();
		test_random_traffic(150);
		test_receiver_hold_off();
		test_random_traffic(150);
		test_pause_until_drained();

		// Let any stray output show up before judging
		drain_results();
		repeat (60) @(negedge clk);

		$display("covered %0d requests: %0d descriptors (%0d data stage), %0d link updates,",
			requests_accepted, desc_seen, data_stage_seen, link_seen);
		$display("%0d rejects, %0d results checked, %0d mismatches",
			reject_seen, results_seen, mismatch_count);
		if (mismatch_count == 0 && pending_trbs.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
